// ===== rtl/core/rfid_frame_id_matcher_defines.svh =====
// Assertion macros shared by the frame matcher RTL.
// Expects clk and rst (synchronous, active high) in the enclosing scope.
`ifndef RFID_FRAME_ID_MATCHER_DEFINES_SVH
`define RFID_FRAME_ID_MATCHER_DEFINES_SVH

// same-cycle implication
`define RFIDM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RFIDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rfidm_pkg.sv =====
// Shared types and constants of the card frame matcher.
// No dependencies.
package rfidm_pkg;

  localparam int ID_LEN_DEF  = 8;
  localparam int NUM_IDS     = 2;
  localparam int ID_IDX_W    = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] STX_CODE = 8'h02;
  localparam logic [7:0] ETX_CODE = 8'h03;

  localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_ZERO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_ONE  = 1'b1;

  localparam logic KIND_ECHO    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic {
    OP_ECHO,
    OP_VERDICT
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [7:0]            data;
    logic                  wr_en;
    logic [ID_IDX_W-1:0]   wr_idx;
    logic                  exact;
    logic                  too_long;
  } op_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] echo_byte;
    logic       card_valid;
    logic       matched_entry;
    logic       frame_too_long;
  } res_t;

endpackage

// ===== rtl/core/rfidm_if.sv =====
// Valid/ready channel interfaces: received bytes in, result words out.
// Depends on rfidm_pkg.
interface rfidm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfidm_result_if import rfidm_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rfidm_front.sv =====
// Front end: frame tracking and classification of received bytes into ops.
// Depends on rfidm_pkg, rfidm_if and the defines header.
`include "rfid_frame_id_matcher_defines.svh"

module rfidm_front import rfidm_pkg::*; #(
  parameter int ID_LEN = ID_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rfidm_byte_if.sink  rx,
  output logic        op_valid,
  output op_t         op,
  input  logic        op_ready
);

  localparam int CNT_W = $clog2(ID_LEN + 2);
  localparam int IDX_W = (ID_LEN > 1) ? $clog2(ID_LEN) : 1;
  localparam logic [CNT_W-1:0] LEN_C = CNT_W'(ID_LEN);

  logic             in_frame, in_frame_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             acc, is_stx, is_etx;

  assign rx.ready = op_ready;
  assign acc      = rx.valid && rx.ready;
  assign is_stx   = rx.rx_byte == STX_CODE;
  assign is_etx   = rx.rx_byte == ETX_CODE;

  always_comb begin
    op.kind     = is_etx ? OP_VERDICT : OP_ECHO;
    op.data     = rx.rx_byte;
    op.wr_en    = !is_etx && (byte_count < LEN_C);
    op.wr_idx   = ID_IDX_W'(byte_count[IDX_W-1:0]);
    op.exact    = byte_count == LEN_C;
    op.too_long = byte_count > LEN_C;
    op_valid    = rx.valid && in_frame && !is_stx;
  end

  always_comb begin
    in_frame_next   = in_frame;
    byte_count_next = byte_count;
    if (acc) begin
      if (is_stx) begin
        in_frame_next   = 1'b1;
        byte_count_next = '0;
      end else if (in_frame) begin
        if (is_etx) begin
          in_frame_next   = 1'b0;
          byte_count_next = '0;
        end else if (byte_count <= LEN_C) begin
          byte_count_next = byte_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else begin
      in_frame   <= in_frame_next;
      byte_count <= byte_count_next;
    end
  end

  `RFIDM_ASSERT_IMPL(a_count_bound, 1'b1, byte_count <= LEN_C + 1'b1, "byte count past limit")
  `RFIDM_ASSERT_NEXT(a_stx_opens, acc && is_stx, in_frame && byte_count == '0, "STX did not open frame")

endmodule

// ===== rtl/core/rfidm_queue.sv =====
// Two-entry op queue between front and back end.
// Depends on rfidm_pkg and the defines header.
`include "rfid_frame_id_matcher_defines.svh"

module rfidm_queue import rfidm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  op_t  push_op,
  output logic push_ready,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != DEPTH_C;
  assign pop_valid  = count != '0;
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RFIDM_ASSERT_NEXT(a_pop_only, pop && !push, count == $past(count) - 1'b1, "queue count slip")

endmodule

// ===== rtl/core/rfidm_back.sv =====
// Back end: identifier store, whitelist compare and registered result word.
// Depends on rfidm_pkg, rfidm_if and the defines header.
`include "rfid_frame_id_matcher_defines.svh"

module rfidm_back import rfidm_pkg::*; #(
  parameter int ID_LEN = ID_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  op_valid,
  input  op_t                   op,
  output logic                  op_ready,
  rfidm_result_if.source        res
);

  localparam int IDX_W = (ID_LEN > 1) ? $clog2(ID_LEN) : 1;
  localparam int LEN_B = ID_LEN * 8;

  logic [7:0]       id_store [ID_LEN];
  logic [LEN_B-1:0] card_id_zero, card_id_one;
  logic [LEN_B-1:0] packed_id;
  logic             match0, match1, take;
  res_t             res_q, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      card_id_zero <= '0;
      card_id_one  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CARD_ID_ZERO: card_id_zero <= cfg_data[LEN_B-1:0];
        REG_CARD_ID_ONE:  card_id_one  <= cfg_data[LEN_B-1:0];
        default: ;
      endcase
    end
  end

  // first received byte in the top bits
  always_comb begin
    for (int k = 0; k < ID_LEN; k++) begin
      packed_id[(ID_LEN-1-k)*8 +: 8] = id_store[k];
    end
  end

  assign match0   = (NUM_IDS >= 1) && (packed_id == card_id_zero);
  assign match1   = (NUM_IDS >= 2) && (packed_id == card_id_one);
  assign take     = op_valid && (!res.valid || res.ready);
  assign op_ready = take;

  always_comb begin
    res_next.result_kind    = KIND_ECHO;
    res_next.echo_byte      = op.data;
    res_next.card_valid     = 1'b0;
    res_next.matched_entry  = 1'b0;
    res_next.frame_too_long = 1'b0;
    if (op.kind == OP_VERDICT) begin
      res_next.result_kind    = KIND_VERDICT;
      res_next.echo_byte      = '0;
      res_next.card_valid     = op.exact && (match0 || match1);
      res_next.matched_entry  = op.exact && !match0 && match1;
      res_next.frame_too_long = op.too_long;
    end
  end

  always_ff @(posedge clk) begin
    if (take && op.wr_en) begin
      id_store[op.wr_idx[IDX_W-1:0]] <= op.data;
    end
    if (take) begin
      res_q <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  assign res.data = res_q;

  `RFIDM_ASSERT_IMPL(a_valid_not_long, res.valid && res.data.card_valid, !res.data.frame_too_long && res.data.result_kind == KIND_VERDICT, "valid verdict on bad frame")

endmodule

// ===== rtl/core/rfid_frame_id_matcher.sv =====
// Channel  Dir  Word                          Handshake
// rx       in   rx_byte [7:0]                 valid/ready
// res      out  kind, echo, valid, entry, tl  valid/ready
// cfg      in   index [0:0], data [63:0]      write enable only
// One byte per cycle sustained while res is ready; each result passes front classify,
// the queue register and the back compare into the output register.
// STX and bytes outside a frame give no result; rx stalls only while the queue is full.
// The two-entry queue lets the front keep taking bytes while res is stalled.
// Synchronous active-high reset clears frame state, queue and output valid.
// Depends on rfidm_pkg, rfidm_if, rfidm_front, rfidm_queue, rfidm_back.
module rfid_frame_id_matcher import rfidm_pkg::*; #(
  parameter int ID_LEN = ID_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  rfidm_byte_if.sink            rx,
  rfidm_result_if.source        res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic f_valid, f_ready, b_valid, b_ready;
  op_t  f_op, b_op;

  rfidm_front #(.ID_LEN(ID_LEN)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .op_valid (f_valid),
    .op       (f_op),
    .op_ready (f_ready)
  );

  rfidm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_op    (f_op),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_op     (b_op),
    .pop_ready  (b_ready)
  );

  rfidm_back #(.ID_LEN(ID_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (b_valid),
    .op        (b_op),
    .op_ready  (b_ready),
    .res       (res)
  );

endmodule
